@@ design/sacf_pkg.sv @@
// ----------------------------------------------------------------------------
// sacf_pkg
// shared types and constants of the set associative tag cache
// ----------------------------------------------------------------------------
package sacf_pkg;

   localparam int NARROW_INDEX_BITS = 4;   // 16 sets
   localparam int WIDE_INDEX_BITS   = 8;   // 256 sets
   localparam int CSR_INDEX_W       = 1;
   localparam int WAYS_REG_W        = 3;
   localparam int CSR_DATA_W        = 3;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic OP_WRITE = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SET_COUNT_MODE = 1'b0,
      CSR_ASSOC_WAYS     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic                  set_count_mode;
      logic [WAYS_REG_W-1:0] assoc_ways;
   } cfg_type;

endpackage

@@ design/sacf_ram.sv @@
// ----------------------------------------------------------------------------
// sacf_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module sacf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/sacf_front.sv @@
// ----------------------------------------------------------------------------
// sacf_front
// accepts access transactions, derives the set index, queues them
// ----------------------------------------------------------------------------
module sacf_front #(
   parameter int MAX_SETS   = 256,
   parameter int ADDR_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sacf_pkg::cfg_type           cfg,
   input  logic                        back_clearing,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_operation,
   input  logic [ADDR_WIDTH-1:0]       req_address,
   output logic                        q_valid,
   input  logic                        q_pop,
   output logic                        q_operation,
   output logic [ADDR_WIDTH-1:0]       q_address,
   output logic [$clog2(MAX_SETS)-1:0] q_set
);
   import sacf_pkg::*;

   localparam int SET_W = $clog2(MAX_SETS);
   localparam int QP_W  = $clog2(QUEUE_DEPTH);
   localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

   logic                  op_ff   [QUEUE_DEPTH];
   logic [ADDR_WIDTH-1:0] addr_ff [QUEUE_DEPTH];
   logic [SET_W-1:0]      set_ff  [QUEUE_DEPTH];
   logic [QP_W-1:0]       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]       count_ff, count_in;
   logic                  push;
   logic [SET_W-1:0]      set_index;

   // low four or eight address bits, then modulo the set count
   always_comb begin
      set_index = '0;
      for (int i = 0; i < SET_W; i++) begin
         if (i < NARROW_INDEX_BITS) begin
            set_index[i] = req_address[i];
         end else if (i < WIDE_INDEX_BITS) begin
            set_index[i] = cfg.set_count_mode & req_address[i];
         end
      end
   end

   assign req_stall = back_clearing || (count_ff == QC_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff]   <= req_operation;
         addr_ff[wr_ptr_ff] <= req_address;
         set_ff[wr_ptr_ff]  <= set_index;
      end
   end

   assign q_valid     = (count_ff != '0);
   assign q_operation = op_ff[rd_ptr_ff];
   assign q_address   = addr_ff[rd_ptr_ff];
   assign q_set       = set_ff[rd_ptr_ff];

endmodule

@@ design/sacf_back.sv @@
// ----------------------------------------------------------------------------
// sacf_back
// tag lookup, fifo replacement, counters and result register
// ----------------------------------------------------------------------------
module sacf_back #(
   parameter int MAX_SETS    = 256,
   parameter int MAX_WAYS    = 4,
   parameter int ADDR_WIDTH  = 32,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sacf_pkg::cfg_type           cfg,
   output logic                        clearing,
   input  logic                        q_valid,
   output logic                        q_pop,
   input  logic                        q_operation,
   input  logic [ADDR_WIDTH-1:0]       q_address,
   input  logic [$clog2(MAX_SETS)-1:0] q_set,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_hit,
   output logic [1:0]                  rsp_way_used,
   output logic [COUNT_WIDTH-1:0]      rsp_hit_count,
   output logic [COUNT_WIDTH-1:0]      rsp_miss_count,
   output logic [COUNT_WIDTH-1:0]      rsp_read_count,
   output logic [COUNT_WIDTH-1:0]      rsp_write_count
);
   import sacf_pkg::*;

   localparam int SET_W  = $clog2(MAX_SETS);
   localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WAYS_W = $clog2(MAX_WAYS + 1);

   typedef enum logic [2:0] {
      S_CLEAR   = 3'b001,
      S_IDLE    = 3'b010,
      S_RESOLVE = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [SET_W-1:0]      clr_ff, clr_in;
   logic                  cur_op_ff;
   logic [ADDR_WIDTH-1:0] cur_addr_ff;
   logic [SET_W-1:0]      cur_set_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff;
   logic [1:0]            rsp_way_ff;
   logic [COUNT_WIDTH-1:0] hits_ff, misses_ff, reads_ff, writes_ff;

   logic [ADDR_WIDTH-1:0] tag_rd [MAX_WAYS];
   logic [WAY_W-1:0]      ptr_rd;
   logic [WAYS_W-1:0]     ways;
   logic                  hit;
   logic [WAY_W-1:0]      found;
   logic [WAY_W-1:0]      victim;
   logic [WAY_W-1:0]      next_ptr;
   logic                  go;
   logic                  miss_wr;
   logic                  ram_we;
   logic [SET_W-1:0]      ram_waddr;
   logic [SET_W-1:0]      ram_raddr;

   // way count clamped to one .. MAX_WAYS
   always_comb begin
      if (cfg.assoc_ways == '0) begin
         ways = WAYS_W'(1);
      end else if (int'(cfg.assoc_ways) > MAX_WAYS) begin
         ways = WAYS_W'(MAX_WAYS);
      end else begin
         ways = WAYS_W'(cfg.assoc_ways);
      end
   end

   // lowest matching way wins
   always_comb begin
      hit   = 1'b0;
      found = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if ((w < int'(ways)) && (tag_rd[w] == cur_addr_ff)) begin
            hit   = 1'b1;
            found = WAY_W'(w);
         end
      end
   end

   // stale pointer falls back to way zero
   always_comb begin
      victim = (int'(ptr_rd) >= int'(ways)) ? '0 : ptr_rd;
      if (int'(victim) + 1 == int'(ways)) begin
         next_ptr = '0;
      end else begin
         next_ptr = WAY_W'(int'(victim) + 1);
      end
   end

   assign go        = (state_ff == S_RESOLVE) && (!rsp_valid_ff || !rsp_stall);
   assign miss_wr   = go && !hit;
   assign clearing  = (state_ff == S_CLEAR);
   assign q_pop     = (state_ff == S_IDLE) && q_valid;
   assign ram_we    = clearing || miss_wr;
   assign ram_waddr = clearing ? clr_ff : cur_set_ff;
   assign ram_raddr = (state_ff == S_IDLE) ? q_set : cur_set_ff;

   for (genvar w = 0; w < MAX_WAYS; w++) begin : g_way
      sacf_ram #(
         .WIDTH (ADDR_WIDTH),
         .DEPTH (MAX_SETS)
      ) u_tag_ram (
         .clock   (clock),
         .wr_en   (clearing || (miss_wr && (victim == WAY_W'(w)))),
         .wr_addr (ram_waddr),
         .wr_data (clearing ? '0 : cur_addr_ff),
         .rd_addr (ram_raddr),
         .rd_data (tag_rd[w])
      );
   end

   sacf_ram #(
      .WIDTH (WAY_W),
      .DEPTH (MAX_SETS)
   ) u_ptr_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (clearing ? '0 : next_ptr),
      .rd_addr (ram_raddr),
      .rd_data (ptr_rd)
   );

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               state_in = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            if (go) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         reads_ff     <= '0;
         writes_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (go) begin
            hits_ff   <= hits_ff + COUNT_WIDTH'(hit);
            misses_ff <= misses_ff + COUNT_WIDTH'(!hit);
            writes_ff <= writes_ff + COUNT_WIDTH'(cur_op_ff == OP_WRITE);
            reads_ff  <= reads_ff + COUNT_WIDTH'(cur_op_ff != OP_WRITE);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_op_ff   <= q_operation;
         cur_addr_ff <= q_address;
         cur_set_ff  <= q_set;
      end
      if (go) begin
         rsp_hit_ff <= hit;
         rsp_way_ff <= 2'(hit ? found : victim);
      end
   end

   // counters only move when the result register is free, so they hold with it
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_way_used    = rsp_way_ff;
   assign rsp_hit_count   = hits_ff;
   assign rsp_miss_count  = misses_ff;
   assign rsp_read_count  = reads_ff;
   assign rsp_write_count = writes_ff;

`ifndef SYNTH
   a_no_pop_while_clearing : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !q_pop)
      else $error("queue popped during clearing pass");

   a_victim_in_range : assert property (@(posedge clock) disable iff (reset)
      miss_wr |-> (int'(victim) < int'(ways)))
      else $error("victim way beyond way count");

   a_counts_advance : assert property (@(posedge clock) disable iff (reset)
      go |=> ((hits_ff + misses_ff) == ($past(hits_ff) + $past(misses_ff) + 1'b1)
              && rsp_valid_ff))
      else $error("hit and miss counts did not advance by one");
`endif

endmodule

@@ design/set_assoc_cache_fifo_model.sv @@
// ----------------------------------------------------------------------------
// set_assoc_cache_fifo_model
// set associative tag cache with fifo replacement and access counters
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every set of the tag and
// pointer rams and holds req_stall high meanwhile; csr writes are taken at
// any time. Each access transaction then passes through the back end as a
// registered ram read of the set in the idle state, then compare, replace
// and count in the resolve state, so the back end takes a new transaction
// only after the last one has resolved. A two entry queue sits between the
// front end and the back end, and the result register lets a new lookup start
// while a result waits. Tags reset to zero with no valid bits, so address zero
// hits in a fresh set.
// ----------------------------------------------------------------------------
module set_assoc_cache_fifo_model #(
   parameter int MAX_SETS    = 256,
   parameter int MAX_WAYS    = 4,
   parameter int ADDR_WIDTH  = 32,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_write_enable,
   input  logic [sacf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [sacf_pkg::CSR_DATA_W-1:0]    csr_write_data,
   // access transactions
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_operation,
   input  logic [ADDR_WIDTH-1:0]              req_address,
   // result transactions
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_hit,
   output logic [1:0]                         rsp_way_used,
   output logic [COUNT_WIDTH-1:0]             rsp_hit_count,
   output logic [COUNT_WIDTH-1:0]             rsp_miss_count,
   output logic [COUNT_WIDTH-1:0]             rsp_read_count,
   output logic [COUNT_WIDTH-1:0]             rsp_write_count
);
   import sacf_pkg::*;

   localparam int SET_W = $clog2(MAX_SETS);

   cfg_type               cfg_ff, cfg_in;
   logic                  clearing;
   logic                  q_valid;
   logic                  q_pop;
   logic                  q_operation;
   logic [ADDR_WIDTH-1:0] q_address;
   logic [SET_W-1:0]      q_set;

   // register file: mode bit and way count
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_SET_COUNT_MODE: cfg_in.set_count_mode = csr_write_data[0];
            CSR_ASSOC_WAYS:     cfg_in.assoc_ways     = csr_write_data[WAYS_REG_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set_count_mode <= 1'b0;
         cfg_ff.assoc_ways     <= WAYS_REG_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front end: accept and index
   sacf_front #(
      .MAX_SETS   (MAX_SETS),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .back_clearing (clearing),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_address   (req_address),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .q_operation   (q_operation),
      .q_address     (q_address),
      .q_set         (q_set)
   );

   // back end: lookup, replace, count
   sacf_back #(
      .MAX_SETS    (MAX_SETS),
      .MAX_WAYS    (MAX_WAYS),
      .ADDR_WIDTH  (ADDR_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .clearing        (clearing),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_operation     (q_operation),
      .q_address       (q_address),
      .q_set           (q_set),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hit         (rsp_hit),
      .rsp_way_used    (rsp_way_used),
      .rsp_hit_count   (rsp_hit_count),
      .rsp_miss_count  (rsp_miss_count),
      .rsp_read_count  (rsp_read_count),
      .rsp_write_count (rsp_write_count)
   );

endmodule
